### sv/sfj_pkg.sv
// ----------------------------------------------------------------------------
// sfj_pkg
// Shared types and constants for the stair sensor fusion judge: payload
// structs, register indexes, class codes, gate bit positions and windows.
// ----------------------------------------------------------------------------
package sfj_pkg;

  // configuration port
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED    = 3'd0,
    REG_MODE       = 3'd1,
    REG_PROFILE    = 3'd2,
    REG_AUTO_LOWER = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic enabled;
    logic mode;        // 0 climb up, 1 descend
    logic profile;     // 0 center, 1 side
    logic auto_lower;
  } cfg_t;

  // input item
  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] front_mm;
    logic        front_ok;
    logic [31:0] front_frame;
    logic [15:0] leg_mm;
    logic        leg_ok;
    logic [31:0] leg_frame;
    logic [15:0] aux_mm;
    logic        aux_ok;
    logic [31:0] aux_frame;
    logic [5:0]  gate_bits;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [1:0] front_class;
    logic [1:0] aux_class;
    logic [1:0] leg_class;
    logic       suggest_climb;
    logic       descend_hint;
    logic       descend_edge_ready;
    logic       go_edge_high;
    logic       go_edge_low;
    logic       lower_after_climb;
    logic       lower_after_descend;
    logic       front_unblock_latched;
  } out_item_t;

  // freshness flags of the three lasers
  typedef struct packed {
    logic front;
    logic leg;
    logic aux;
  } fresh_t;

  // front laser classes
  localparam logic [1:0] FC_INVALID = 2'd0;
  localparam logic [1:0] FC_FAR     = 2'd1;
  localparam logic [1:0] FC_NEAR    = 2'd2;
  localparam logic [1:0] FC_EDGE    = 2'd3;

  // leg laser classes
  localparam logic [1:0] LC_INVALID = 2'd0;
  localparam logic [1:0] LC_STEP    = 2'd1;
  localparam logic [1:0] LC_GROUND  = 2'd2;
  localparam logic [1:0] LC_HIGH    = 2'd3;

  // gate bit positions
  localparam int GATE_FRONT_CLEAR      = 0;
  localparam int GATE_FRONT_CLEAR_EDGE = 1;
  localparam int GATE_REAR_BLOCKED     = 2;
  localparam int GATE_REAR_CLEAR       = 3;
  localparam int GATE_REAR_BLOCK_EDGE  = 4;
  localparam int GATE_REAR_CLEAR_EDGE  = 5;

  // timing
  localparam logic [31:0] TIMEOUT_MS = 32'd500;
  localparam logic [31:0] HOLD_MS    = 32'd3;

  // distance windows in mm
  localparam logic [15:0] EDGE_MIN       = 16'd800;
  localparam logic [15:0] NEAR_LO        = 16'd400;
  localparam logic [15:0] FRONT_NEAR_HI  = 16'd435;
  localparam logic [15:0] FRONT_GO_C_HI  = 16'd423;
  localparam logic [15:0] FRONT_GO_S_LO  = 16'd430;
  localparam logic [15:0] FRONT_GO_S_HI  = 16'd504;
  localparam logic [15:0] AUX_NEAR_C_HI  = 16'd470;
  localparam logic [15:0] AUX_GO_C_HI    = 16'd435;
  localparam logic [15:0] AUX_SIDE_HI    = 16'd510;
  localparam logic [15:0] LEG_STEP_HI    = 16'd449;
  localparam logic [15:0] LEG_GROUND_HI  = 16'd800;
  localparam logic [15:0] LEG_HIGH_HI    = 16'd1400;
  localparam logic [15:0] LEG_CLIMB_LO   = 16'd170;
  localparam logic [15:0] LEG_CLIMB_HI   = 16'd240;
  localparam logic [15:0] LEG_LOWER_LO   = 16'd280;
  localparam logic [15:0] LEG_LOWER_HI   = 16'd500;
  localparam logic [15:0] LEG_GO_LO      = 16'd500;
  localparam logic [15:0] LEG_GO_HI      = 16'd700;

  function automatic logic in_window(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

### sv/sfj_fresh.sv
// ----------------------------------------------------------------------------
// sfj_fresh
// Frame tracker for one laser: remembers the last frame counter and when it
// changed, and flags the laser fresh while frames keep arriving.
// ----------------------------------------------------------------------------
module sfj_fresh import sfj_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [31:0] now_ms,
  input  logic [31:0] frame,
  input  logic        ok,
  output logic        fresh
);

  logic [31:0] seen_r;
  logic [31:0] stamp_r;
  logic        changed;
  logic [31:0] age;

  // a new frame counter restamps the age to zero
  assign changed = (frame != seen_r);
  assign age     = now_ms - stamp_r;
  assign fresh   = ok && (frame != 32'd0) && (changed || (age <= TIMEOUT_MS));

  // frame history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      stamp_r <= '0;
    end else if (step && changed) begin
      seen_r  <= frame;
      stamp_r <= now_ms;
    end
  end

endmodule

### sv/sfj_judge.sv
// ----------------------------------------------------------------------------
// sfj_judge
// Classifies the three lasers, keeps the gate latches and the front hold
// timer, and forms the suggestions of the selected mode for one item.
// ----------------------------------------------------------------------------
module sfj_judge import sfj_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic      clr,
  input  cfg_t      cfg,
  input  in_item_t  item,
  input  fresh_t    fresh,
  output out_item_t res
);

  logic        rear_block_r,   rear_block_nxt;
  logic        rear_unblock_r, rear_unblock_nxt;
  logic        front_unblk_r,  front_unblk_nxt;
  logic        hold_r,         hold_nxt;
  logic [31:0] since_r,        since_nxt;

  logic        side;
  logic        climb;
  logic [31:0] since_eff;
  logic [15:0] aux_near_hi;
  logic [15:0] aux_go_hi;
  logic        go_front;
  logic        go_aux;
  logic        rb_upd, ru_upd, fu_upd, hold_upd;
  logic [31:0] since_upd;
  logic [1:0]  front_cls;
  logic [1:0]  aux_cls;
  logic [1:0]  leg_cls;

  assign side        = cfg.profile;
  assign climb       = !cfg.mode;
  assign aux_near_hi = side ? AUX_SIDE_HI : AUX_NEAR_C_HI;
  assign aux_go_hi   = side ? AUX_SIDE_HI : AUX_GO_C_HI;

  // latch and hold update for this item
  always_comb begin
    fu_upd    = front_unblk_r  | item.gate_bits[GATE_FRONT_CLEAR_EDGE];
    rb_upd    = rear_block_r   | item.gate_bits[GATE_REAR_BLOCK_EDGE];
    ru_upd    = rear_unblock_r | item.gate_bits[GATE_REAR_CLEAR_EDGE];
    since_eff = (since_r == 32'd0) ? item.now_ms : since_r;
    if (item.gate_bits[GATE_FRONT_CLEAR]) begin
      since_upd = since_eff;
      hold_upd  = ((item.now_ms - since_eff) >= HOLD_MS);
    end else begin
      since_upd = '0;
      hold_upd  = 1'b0;
    end
  end

  // classes, given even while disabled
  always_comb begin
    priority if (!fresh.front)            front_cls = FC_INVALID;
    else if (item.front_mm >= EDGE_MIN)   front_cls = FC_EDGE;
    else if (in_window(item.front_mm, NEAR_LO, FRONT_NEAR_HI))
                                          front_cls = FC_NEAR;
    else                                  front_cls = FC_FAR;

    priority if (!fresh.aux)              aux_cls = FC_INVALID;
    else if (item.aux_mm >= EDGE_MIN)     aux_cls = FC_EDGE;
    else if (in_window(item.aux_mm, NEAR_LO, aux_near_hi))
                                          aux_cls = FC_NEAR;
    else                                  aux_cls = FC_FAR;

    priority if (!fresh.leg)              leg_cls = LC_INVALID;
    else if (item.leg_mm <= LEG_STEP_HI)  leg_cls = LC_STEP;
    else if (item.leg_mm <= LEG_GROUND_HI) leg_cls = LC_GROUND;
    else if (item.leg_mm <= LEG_HIGH_HI)  leg_cls = LC_HIGH;
    else                                  leg_cls = LC_INVALID;
  end

  // go-edge windows of the front lasers
  assign go_front = fresh.front &&
                    (side ? in_window(item.front_mm, FRONT_GO_S_LO, FRONT_GO_S_HI)
                          : in_window(item.front_mm, NEAR_LO, FRONT_GO_C_HI));
  assign go_aux   = fresh.aux && in_window(item.aux_mm, NEAR_LO, aux_go_hi);

  // result item, suggestions all zero while disabled
  always_comb begin
    res.front_class           = front_cls;
    res.aux_class             = aux_cls;
    res.leg_class             = leg_cls;
    res.suggest_climb         = 1'b0;
    res.descend_hint          = 1'b0;
    res.descend_edge_ready    = 1'b0;
    res.go_edge_high          = 1'b0;
    res.go_edge_low           = 1'b0;
    res.lower_after_climb     = 1'b0;
    res.lower_after_descend   = 1'b0;
    res.front_unblock_latched = 1'b0;
    if (cfg.enabled) begin
      res.suggest_climb = climb &&
        ((front_cls == FC_NEAR) || (aux_cls == FC_NEAR) ||
         (fresh.leg && in_window(item.leg_mm, LEG_CLIMB_LO, LEG_CLIMB_HI)));
      res.descend_hint          = !climb && (ru_upd || item.gate_bits[GATE_REAR_CLEAR]);
      res.descend_edge_ready    = (front_cls == FC_EDGE);
      res.go_edge_high          = go_front || go_aux;
      res.go_edge_low           = (fresh.leg && in_window(item.leg_mm, LEG_GO_LO, LEG_GO_HI))
                                  || hold_upd;
      res.lower_after_climb     = cfg.auto_lower && climb &&
                                  (rb_upd || item.gate_bits[GATE_REAR_BLOCKED]);
      res.lower_after_descend   = cfg.auto_lower && !climb && fresh.leg &&
                                  in_window(item.leg_mm, LEG_LOWER_LO, LEG_LOWER_HI);
      res.front_unblock_latched = fu_upd;
    end
  end

  // next state: changed enable or mode and any auto-lower write clear progress, disabled clears after each item
  always_comb begin
    rear_block_nxt   = rear_block_r;
    rear_unblock_nxt = rear_unblock_r;
    front_unblk_nxt  = front_unblk_r;
    hold_nxt         = hold_r;
    since_nxt        = since_r;
    if (clr || (step && !cfg.enabled)) begin
      rear_block_nxt   = 1'b0;
      rear_unblock_nxt = 1'b0;
      front_unblk_nxt  = 1'b0;
      hold_nxt         = 1'b0;
      since_nxt        = '0;
    end else if (step) begin
      rear_block_nxt   = rb_upd;
      rear_unblock_nxt = ru_upd;
      front_unblk_nxt  = fu_upd;
      hold_nxt         = hold_upd;
      since_nxt        = since_upd;
    end
  end

  // progress registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rear_block_r   <= 1'b0;
      rear_unblock_r <= 1'b0;
      front_unblk_r  <= 1'b0;
      hold_r         <= 1'b0;
      since_r        <= '0;
    end else begin
      rear_block_r   <= rear_block_nxt;
      rear_unblock_r <= rear_unblock_nxt;
      front_unblk_r  <= front_unblk_nxt;
      hold_r         <= hold_nxt;
      since_r        <= since_nxt;
    end
  end

endmodule

### sv/stair_sensor_fusion_judge.sv
// ----------------------------------------------------------------------------
// stair_sensor_fusion_judge
// Fuses three laser distances and the photogate bits of each tick into
// laser classes and stair assist suggestions.
//
//   channel  ports                         payload
//   input    in_valid / in_ready           in_data   (in_item_t)
//   result   out_valid / out_ready         out_data  (out_item_t)
//   config   cfg_valid / cfg_ready         cfg_idx, cfg_wdata
//
// One item per cycle while the result side keeps up; an item passes the input
// register, then the judge logic into the result register.
// Synchronous reset clears the valid flags, config and progress state; no clearing pass.
// A stalled result register holds the input register, and once that is
// also full in_ready drops; config writes are always taken.
// ----------------------------------------------------------------------------
module stair_sensor_fusion_judge import sfj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic                 cfg_wdata
);

  in_item_t  item_r;
  logic      item_vld_r;
  out_item_t res_r;
  logic      res_vld_r;
  cfg_t      cfg_r, cfg_nxt;
  logic      clr;
  logic      advance;
  logic      step;
  fresh_t    fresh;
  out_item_t res;

  // handshake
  assign advance   = !res_vld_r || out_ready;
  assign step      = item_vld_r && advance;
  assign in_ready  = !item_vld_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  // register writes and progress clear
  always_comb begin
    cfg_nxt = cfg_r;
    clr     = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_idx)
        REG_ENABLED: begin
          cfg_nxt.enabled = cfg_wdata;
          clr = (cfg_wdata != cfg_r.enabled);
        end
        REG_MODE: begin
          cfg_nxt.mode = cfg_wdata;
          clr = (cfg_wdata != cfg_r.mode);
        end
        REG_PROFILE: begin
          cfg_nxt.profile = cfg_wdata;
        end
        REG_AUTO_LOWER: begin
          cfg_nxt.auto_lower = cfg_wdata;
          clr = 1'b1;
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  // laser frame trackers
  sfj_fresh u_fresh_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .now_ms (item_r.now_ms),
    .frame  (item_r.front_frame),
    .ok     (item_r.front_ok),
    .fresh  (fresh.front)
  );

  sfj_fresh u_fresh_leg (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .now_ms (item_r.now_ms),
    .frame  (item_r.leg_frame),
    .ok     (item_r.leg_ok),
    .fresh  (fresh.leg)
  );

  sfj_fresh u_fresh_aux (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .now_ms (item_r.now_ms),
    .frame  (item_r.aux_frame),
    .ok     (item_r.aux_ok),
    .fresh  (fresh.aux)
  );

  // classification, latches and suggestions
  sfj_judge u_judge (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .clr   (clr),
    .cfg   (cfg_r),
    .item  (item_r),
    .fresh (fresh),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

endmodule

### dv/tb_stair_sensor_fusion_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stair_sensor_fusion_judge
// Self-checking bench for the stair sensor fusion judge. A scoreboard class
// predicts every result from its own copy of the laser tracking, gate
// latches, front hold timer and registers. Ticks run as time-ordered
// sequences with random content, boundary-heavy distances and some noise.
// Both channels idle at random, and the result side holds off once to fill
// the block. Register settings change only while the block is drained.
// ----------------------------------------------------------------------------
module tb_stair_sensor_fusion_judge;
  import sfj_pkg::*;

  localparam int LASER_FRONT     = 0;
  localparam int LASER_LEG       = 1;
  localparam int LASER_AUX       = 2;
  localparam int PHASE_TICKS     = 200;
  localparam int PHASE_COUNT     = 8;
  localparam int PRESSURE_AT     = 300;
  localparam int PRESSURE_CYCLES = 64;
  localparam int SETTLE_CYCLES   = 8;

  // gate masks
  localparam bit [5:0] G_FC  = 6'(1 << GATE_FRONT_CLEAR);
  localparam bit [5:0] G_FCE = 6'(1 << GATE_FRONT_CLEAR_EDGE);
  localparam bit [5:0] G_RB  = 6'(1 << GATE_REAR_BLOCKED);
  localparam bit [5:0] G_RC  = 6'(1 << GATE_REAR_CLEAR);
  localparam bit [5:0] G_RBE = 6'(1 << GATE_REAR_BLOCK_EDGE);
  localparam bit [5:0] G_RCE = 6'(1 << GATE_REAR_CLEAR_EDGE);

  // window edges that distances cluster around
  localparam bit [15:0] WINDOW_EDGES [15] = '{
    LEG_CLIMB_LO, LEG_CLIMB_HI, LEG_LOWER_LO, NEAR_LO, FRONT_GO_C_HI,
    FRONT_GO_S_LO, FRONT_NEAR_HI, LEG_STEP_HI, AUX_NEAR_C_HI, LEG_LOWER_HI,
    FRONT_GO_S_HI, AUX_SIDE_HI, LEG_GO_HI, EDGE_MIN, LEG_HIGH_HI
  };

  // --------------------------------------------------------------------------
  // judge predictor and result store
  // --------------------------------------------------------------------------
  class judge_scoreboard;
    bit        enabled, descend, side, auto_lower;
    bit [31:0] frame_seen [3];
    bit [31:0] frame_stamp [3];
    bit        rear_block_l, rear_clear_l, front_clear_l, hold_ready;
    bit [31:0] clear_start;
    out_item_t expected_q [$];
    int        errors, ticks_noted, results_checked, reg_writes;

    function void drop_progress();
      rear_block_l  = 1'b0;
      rear_clear_l  = 1'b0;
      front_clear_l = 1'b0;
      clear_start   = '0;
      hold_ready    = 1'b0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit v);
      reg_writes++;
      case (idx)
        REG_ENABLED: begin
          if (v != enabled) begin
            enabled = v;
            drop_progress();
          end
        end
        REG_MODE: begin
          if (v != descend) begin
            descend = v;
            drop_progress();
          end
        end
        REG_PROFILE: side = v;
        REG_AUTO_LOWER: begin
          auto_lower = v;
          drop_progress();
        end
        default: ;
      endcase
    endfunction

    // new frame number restamps; fresh means ok, seen, and young enough
    function bit refresh(int k, bit [31:0] now, bit [31:0] frame, bit ok);
      bit [31:0] age;
      if (frame != frame_seen[k]) begin
        frame_seen[k]  = frame;
        frame_stamp[k] = now;
      end
      age = now - frame_stamp[k];
      return ok && frame_seen[k] != 0 && age <= TIMEOUT_MS;
    endfunction

    function bit between(bit [15:0] v, bit [15:0] lo, bit [15:0] hi);
      return v >= lo && v <= hi;
    endfunction

    function bit [1:0] front_kind(bit [15:0] mm, bit fresh, bit [15:0] near_hi);
      if (!fresh) return FC_INVALID;
      if (mm >= EDGE_MIN) return FC_EDGE;
      if (between(mm, NEAR_LO, near_hi)) return FC_NEAR;
      return FC_FAR;
    endfunction

    function out_item_t judge(in_item_t t);
      out_item_t r;
      bit        f_fresh, l_fresh, a_fresh;
      bit [31:0] held;
      r = '0;
      f_fresh = refresh(LASER_FRONT, t.now_ms, t.front_frame, t.front_ok);
      a_fresh = refresh(LASER_AUX, t.now_ms, t.aux_frame, t.aux_ok);
      l_fresh = refresh(LASER_LEG, t.now_ms, t.leg_frame, t.leg_ok);

      // classes are given even while disabled
      r.front_class = front_kind(t.front_mm, f_fresh, FRONT_NEAR_HI);
      r.aux_class   = front_kind(t.aux_mm, a_fresh, side ? AUX_SIDE_HI : AUX_NEAR_C_HI);
      if (!l_fresh || t.leg_mm > LEG_HIGH_HI) r.leg_class = LC_INVALID;
      else if (t.leg_mm <= LEG_STEP_HI) r.leg_class = LC_STEP;
      else if (t.leg_mm <= LEG_GROUND_HI) r.leg_class = LC_GROUND;
      else r.leg_class = LC_HIGH;

      // gate latches and the front hold timer
      if (t.gate_bits[GATE_FRONT_CLEAR_EDGE]) front_clear_l = 1'b1;
      if (t.gate_bits[GATE_FRONT_CLEAR]) begin
        if (clear_start == 0) clear_start = t.now_ms;
        held = t.now_ms - clear_start;
        hold_ready = held >= HOLD_MS;
      end else begin
        clear_start = '0;
        hold_ready  = 1'b0;
      end
      if (t.gate_bits[GATE_REAR_BLOCK_EDGE]) rear_block_l = 1'b1;
      if (t.gate_bits[GATE_REAR_CLEAR_EDGE]) rear_clear_l = 1'b1;

      // disabled: nothing suggested, progress dropped
      if (!enabled) begin
        drop_progress();
        return r;
      end

      r.suggest_climb = !descend && (r.front_class == FC_NEAR || r.aux_class == FC_NEAR ||
                        (l_fresh && between(t.leg_mm, LEG_CLIMB_LO, LEG_CLIMB_HI)));
      r.descend_hint = descend && (rear_clear_l || t.gate_bits[GATE_REAR_CLEAR]);
      r.descend_edge_ready = r.front_class == FC_EDGE;
      r.go_edge_high =
        (f_fresh && (side ? between(t.front_mm, FRONT_GO_S_LO, FRONT_GO_S_HI)
                          : between(t.front_mm, NEAR_LO, FRONT_GO_C_HI))) ||
        (a_fresh && between(t.aux_mm, NEAR_LO, side ? AUX_SIDE_HI : AUX_GO_C_HI));
      r.go_edge_low = (l_fresh && between(t.leg_mm, LEG_GO_LO, LEG_GO_HI)) || hold_ready;
      r.lower_after_climb = auto_lower && !descend &&
                            (rear_block_l || t.gate_bits[GATE_REAR_BLOCKED]);
      r.lower_after_descend = auto_lower && descend && l_fresh &&
                              between(t.leg_mm, LEG_LOWER_LO, LEG_LOWER_HI);
      r.front_unblock_latched = front_clear_l;
      return r;
    endfunction

    function void note_tick(in_item_t t);
      expected_q.push_back(judge(t));
      ticks_noted++;
    endfunction

    function void check_field(string field, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("result with no tick pending: %p", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      check_field("front_class", want.front_class, got.front_class);
      check_field("aux_class", want.aux_class, got.aux_class);
      check_field("leg_class", want.leg_class, got.leg_class);
      check_field("suggest_climb", want.suggest_climb, got.suggest_climb);
      check_field("descend_hint", want.descend_hint, got.descend_hint);
      check_field("descend_edge_ready", want.descend_edge_ready, got.descend_edge_ready);
      check_field("go_edge_high", want.go_edge_high, got.go_edge_high);
      check_field("go_edge_low", want.go_edge_low, got.go_edge_low);
      check_field("lower_after_climb", want.lower_after_climb, got.lower_after_climb);
      check_field("lower_after_descend", want.lower_after_descend,
                  got.lower_after_descend);
      check_field("front_unblock_latched", want.front_unblock_latched,
                  got.front_unblock_latched);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and block
  // --------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic                 cfg_wdata = 1'b0;

  judge_scoreboard sb = new();

  // sequence state for well-formed ticks
  bit [31:0] clock_ms;
  bit [31:0] frame_ctr [3];
  bit        front_clear_lvl, rear_blocked_lvl, rear_clear_lvl;
  bit        steady;

  stair_sensor_fusion_judge dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // mostly no gap, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic bit [15:0] pick_mm();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return WINDOW_EDGES[$urandom_range(0, 14)] + 16'($urandom_range(0, 4)) - 16'd2;
    if (r < 85) return 16'($urandom_range(0, 1500));
    return 16'($urandom);
  endfunction

  // mostly advancing frames, some stalls, resets to zero and jumps
  function automatic bit [31:0] next_frame(int k);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) frame_ctr[k] += 1;
    else if (r < 70) frame_ctr[k] = $urandom;
    else if (r < 73) frame_ctr[k] = '0;
    return frame_ctr[k];
  endfunction

  // small steps, steps around the timeout, wraps and jumps
  function automatic bit [31:0] next_now();
    int r;
    r = $urandom_range(0, 999);
    if (r < 700) clock_ms += $urandom_range(0, 4);
    else if (r < 930) clock_ms += $urandom_range(5, 60);
    else if (r < 980) clock_ms += $urandom_range(440, 560);
    else if (r < 990) clock_ms = 32'hFFFF_FFF0 + $urandom_range(0, 12);
    else clock_ms = $urandom;
    return clock_ms;
  endfunction

  // levels persist over ticks, edges are sparse
  function automatic bit [5:0] next_gate();
    bit [5:0] g;
    if ($urandom_range(0, 9) == 0) front_clear_lvl = !front_clear_lvl;
    if ($urandom_range(0, 9) == 0) rear_blocked_lvl = !rear_blocked_lvl;
    if ($urandom_range(0, 9) == 0) rear_clear_lvl = !rear_clear_lvl;
    g = '0;
    g[GATE_FRONT_CLEAR]      = front_clear_lvl;
    g[GATE_REAR_BLOCKED]     = rear_blocked_lvl;
    g[GATE_REAR_CLEAR]       = rear_clear_lvl;
    g[GATE_FRONT_CLEAR_EDGE] = $urandom_range(0, 11) == 0;
    g[GATE_REAR_BLOCK_EDGE]  = $urandom_range(0, 11) == 0;
    g[GATE_REAR_CLEAR_EDGE]  = $urandom_range(0, 11) == 0;
    return g;
  endfunction

  function automatic in_item_t next_tick();
    in_item_t t;
    // noise item: every field free
    if ($urandom_range(0, 9) == 0) begin
      t.now_ms      = $urandom;
      t.front_mm    = 16'($urandom);
      t.front_ok    = 1'($urandom);
      t.front_frame = $urandom;
      t.leg_mm      = 16'($urandom);
      t.leg_ok      = 1'($urandom);
      t.leg_frame   = $urandom;
      t.aux_mm      = 16'($urandom);
      t.aux_ok      = 1'($urandom);
      t.aux_frame   = $urandom;
      t.gate_bits   = 6'($urandom);
      return t;
    end
    t.now_ms      = next_now();
    t.front_mm    = pick_mm();
    t.front_ok    = $urandom_range(0, 6) != 0;
    t.front_frame = next_frame(LASER_FRONT);
    t.leg_mm      = pick_mm();
    t.leg_ok      = $urandom_range(0, 6) != 0;
    t.leg_frame   = next_frame(LASER_LEG);
    t.aux_mm      = pick_mm();
    t.aux_ok      = $urandom_range(0, 6) != 0;
    t.aux_frame   = next_frame(LASER_AUX);
    t.gate_bits   = next_gate();
    return t;
  endfunction

  function automatic in_item_t tick_of(bit [31:0] now, bit [15:0] f_mm, bit [31:0] f_fr,
                                       bit [15:0] l_mm, bit [31:0] l_fr, bit [15:0] a_mm,
                                       bit [31:0] a_fr, bit ok, bit [5:0] g);
    in_item_t t;
    t.now_ms      = now;
    t.front_mm    = f_mm;
    t.front_ok    = ok;
    t.front_frame = f_fr;
    t.leg_mm      = l_mm;
    t.leg_ok      = ok;
    t.leg_frame   = l_fr;
    t.aux_mm      = a_mm;
    t.aux_ok      = ok;
    t.aux_frame   = a_fr;
    t.gate_bits   = g;
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // valid is lowered only when a gap follows, so it never toggles within a step
  task automatic send_tick(in_item_t t);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(t);
  endtask

  task automatic write_cfg(bit [CFG_IDX_W-1:0] idx, bit v);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // s = {enabled, mode, profile, auto_lower}; partial writes keep latches alive
  task automatic configure(bit [3:0] s, bit all);
    if (all || $urandom_range(0, 3) != 0) write_cfg(REG_ENABLED, s[3]);
    if (all || $urandom_range(0, 3) != 0) write_cfg(REG_MODE, s[2]);
    if (all || $urandom_range(0, 3) != 0) write_cfg(REG_PROFILE, s[1]);
    if (all || $urandom_range(0, 3) != 0) write_cfg(REG_AUTO_LOWER, s[0]);
    // unused index, must be ignored
    if ($urandom_range(0, 2) == 0)
      write_cfg(CFG_IDX_W'(REG_AUTO_LOWER) + CFG_IDX_W'($urandom_range(1, 4)), 1'($urandom));
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // result side: random stalls plus one long hold-off to back up the block
  // --------------------------------------------------------------------------
  initial begin
    int run, stall;
    bit pressed;
    pressed = 1'b0;
    forever begin
      if (!pressed && sb.ticks_noted >= PRESSURE_AT) begin
        pressed = 1'b1;
        out_ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end
      run   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      stall = idle_len();
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // run limit, far above any correct run
  initial begin
    #4_000_000;
    $display("run limit reached with %0d results outstanding", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit [3:0] s;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: enabled, climb, center windows, auto-lower on
    configure(4'b1001, 1'b1);
    // no frame seen yet
    send_tick(tick_of(0, 420, 0, 200, 0, 420, 0, 1'b1, '0));
    // first frames, hold timer starts
    send_tick(tick_of(10, 400, 1, 170, 1, 400, 1, 1'b1, G_FC));
    // hold ready after 3 ms, upper near edges
    send_tick(tick_of(13, 435, 1, 240, 1, 470, 1, 1'b1, G_FC));
    // age exactly at the timeout, edge open and extreme distances
    send_tick(tick_of(510, 800, 1, 1400, 1, 16'hFFFF, 1, 1'b1, G_FC | G_RB));
    // one past the timeout
    send_tick(tick_of(511, 423, 1, 600, 1, 435, 1, 1'b1, G_RBE));
    // new frames but not ok
    send_tick(tick_of(512, 430, 2, 500, 2, 436, 2, 1'b0, G_RCE | G_RC));
    // zero distances, all edges and levels except front clear
    send_tick(tick_of(520, 0, 3, 0, 3, 0, 3, 1'b1, G_FCE | G_RB | G_RC | G_RBE | G_RCE));
    // just before the tick wraps, leg beyond range
    send_tick(tick_of(32'hFFFF_FFFE, 16'hFFFF, 4, 1401, 4, 423, 4, 1'b1, G_FC));
    // across the wrap: still fresh, hold not yet, then ready
    send_tick(tick_of(0, 504, 4, 449, 4, 510, 4, 1'b1, G_FC));
    send_tick(tick_of(1, 505, 4, 450, 4, 511, 4, 1'b1, G_FC));
    // front clear drops and stops the timer
    send_tick(tick_of(2, 799, 5, 800, 5, 799, 5, 1'b1, '0));
    // tick zero leaves the timer unloaded, so it restarts next tick
    send_tick(tick_of(0, 399, 5, 801, 5, 399, 5, 1'b1, G_FC));
    send_tick(tick_of(3, 436, 6, 280, 6, 471, 6, 1'b1, G_FC));
    send_tick(tick_of(6, 424, '1, 700, '1, 434, '1, 1'b1, G_FC | G_FCE));
    // frame counters back to zero
    send_tick(tick_of(7, 429, 0, 701, 0, 400, 0, 1'b1, G_FC));
    send_tick(tick_of(8, 431, 7, 169, 7, 509, 7, 1'b1, G_RB));
    send_tick(tick_of(9, 800, 8, 241, 8, 800, 8, 1'b1, G_RC));
    // same frame, same tick
    send_tick(tick_of(9, 1000, 8, 279, 8, 1, 8, 1'b1, '0));
    // long silence, then a fresh frame
    send_tick(tick_of(1009, 420, 8, 300, 8, 420, 8, 1'b1, '0));
    send_tick(tick_of(1010, 420, 9, 499, 9, 420, 9, 1'b1, '0));

    // random phases, each under its own register setting
    clock_ms = 32'd2000;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      in_valid <= 1'b0;
      drain();
      case (p)
        0: s = 4'b0000;
        1: s = 4'b1111;
        2: s = 4'b1001;
        default: s = {$urandom_range(0, 3) != 0, 3'($urandom)};
      endcase
      configure(s, p < 3);
      steady = (p % 3 == 2);
      repeat (PHASE_TICKS) send_tick(next_tick());
    end
    in_valid <= 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d ticks under %0d register settings, %0d register writes",
             sb.ticks_noted, PHASE_COUNT + 1, sb.reg_writes);
    $display("checked %0d results, %0d mismatches", sb.results_checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
